### sv/psf_pkg.sv
// shared types and sizes for the prime sieve filter chain
// no dependencies; imported by psf_cell and prime_sieve_filter_chain
package psf_pkg;

  localparam int MAX_PRIMES  = 64;
  localparam int VALUE_WIDTH = 16;
  localparam int IDX_W       = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
  localparam int CNT_W       = $clog2(MAX_PRIMES + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);

  // one bit of a candidate moving down the chain, msb first
  typedef struct packed {
    logic vld;
    logic first;
    logic lastb;
    logic dbit;
    logic hit;
  } cell_link_t;

  // broadcast write and clear for the stored primes
  typedef struct packed {
    logic                   wr;
    logic                   clr;
    logic [VALUE_WIDTH-1:0] data;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_PEND
  } state_t;

endpackage

### sv/psf_cell.sv
// one filter cell: holds a stored prime and reduces the passing candidate modulo it
// one restoring division step per beat of the bit stream; depends on psf_pkg
module psf_cell import psf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  cell_link_t link_in,
  output cell_link_t link_out,
  output logic       valid
);

  logic [VALUE_WIDTH-1:0] p;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] rem_next;
  logic [VALUE_WIDTH:0]   partial;
  logic                   step_ge;
  logic                   own_hit;
  cell_link_t             link_out_next;

  always_comb begin
    partial  = {(link_in.first ? {VALUE_WIDTH{1'b0}} : rem), link_in.dbit};
    step_ge  = partial >= {1'b0, p};
    rem_next = step_ge ? VALUE_WIDTH'(partial - {1'b0, p}) : partial[VALUE_WIDTH-1:0];
    own_hit  = link_in.vld && link_in.lastb && valid && (p != '0) && (rem_next == '0);
    link_out_next     = link_in;
    link_out_next.hit = link_in.hit || own_hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= 1'b0;
      link_out <= '0;
    end else begin
      if (ctrl.clr) begin
        valid <= 1'b0;
      end else if (sel && ctrl.wr) begin
        valid <= 1'b1;
      end
      link_out <= link_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.vld) begin
      rem <= rem_next;
    end
    if (sel && ctrl.wr) begin
      p <= ctrl.data;
    end
  end

endmodule

### sv/prime_sieve_filter_chain.sv
// prime sieve filter chain: sequencer, result register and a row of psf_cell
// depends on psf_pkg and psf_cell
//
// usage:
//   input beat (in_valid/in_ready): candidate and last. in_ready is high only
//   while the block is idle, one candidate is worked at a time.
//   output beat (out_valid/out_ready): prime and chain_full, at most one per
//   candidate; a candidate that some stored prime divides gives no beat.
//   the candidate is sent msb first, one bit per cycle, down a row of
//   MAX_PRIMES cells; each cell does one restoring division step per cycle
//   and ors its divides flag into the bit stream. a result is out once the
//   last bit has left the last cell, and the next candidate is taken only
//   after that, so a new candidate never enters before the last is through.
//   a new prime is written into the next free cell; with all cells in use it
//   is sent with chain_full set and not kept. an item with last set clears
//   all cells once it is done.
//   the output register holds a result while the receiver stalls; a second
//   result waits in a pending slot and no new candidate is taken until it
//   has gone out.
//   reset empties all cells and drops any beat in flight.
module prime_sieve_filter_chain import psf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] candidate,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] prime,
  output logic                   chain_full
);

  state_t                 state;
  state_t                 state_next;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [VALUE_WIDTH-1:0] cand_q;
  logic [VALUE_WIDTH-1:0] cand_sh;
  logic                   last_q;
  logic                   pend_full;
  logic [CNT_W-1:0]       count;

  cell_link_t             links [MAX_PRIMES+1];
  logic [MAX_PRIMES-1:0]  cell_valid;
  cell_ctrl_t             ctrl;

  logic done;
  logic produce;
  logic full;
  logic out_busy;

  always_comb begin
    done     = (state == ST_DRAIN) && links[MAX_PRIMES].vld && links[MAX_PRIMES].lastb;
    produce  = !links[MAX_PRIMES].hit;
    full     = count == CNT_W'(MAX_PRIMES);
    out_busy = out_valid && !out_ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_FEED;
      end
      ST_FEED: begin
        if (bit_cnt == BIT_CNT_W'(VALUE_WIDTH - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (done) state_next = (produce && out_busy) ? ST_PEND : ST_IDLE;
      end
      ST_PEND: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = 1'b0;
    links[0]       = '0;
    ctrl.wr        = 1'b0;
    ctrl.clr       = 1'b0;
    ctrl.data      = cand_q;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FEED: begin
        links[0].vld   = 1'b1;
        links[0].first = bit_cnt == '0;
        links[0].lastb = bit_cnt == BIT_CNT_W'(VALUE_WIDTH - 1);
        links[0].dbit  = cand_sh[VALUE_WIDTH-1];
      end
      ST_DRAIN: begin
        ctrl.wr  = done && produce && !full;
        ctrl.clr = done && last_q;
      end
      ST_PEND: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
    psf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .sel      (count[IDX_W-1:0] == IDX_W'(i)),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .valid    (cell_valid[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.clr) begin
        count <= '0;
      end else if (ctrl.wr) begin
        count <= count + CNT_W'(1);
      end
      if (done && produce && !out_busy) begin
        out_valid <= 1'b1;
      end else if (state == ST_PEND && out_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cand_q  <= candidate;
      cand_sh <= candidate;
      last_q  <= last;
      bit_cnt <= '0;
    end else if (state == ST_FEED) begin
      cand_sh <= {cand_sh[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if (done) begin
      pend_full <= full;
    end
    if (done && produce && !out_busy) begin
      prime      <= cand_q;
      chain_full <= full;
    end else if (state == ST_PEND && out_ready) begin
      prime      <= cand_q;
      chain_full <= pend_full;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_in_drain: assert property (@(posedge clk) disable iff (rst)
    links[MAX_PRIMES].vld |-> state == ST_DRAIN)
    else $error("bit stream left the chain outside drain");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PRIMES))
    else $error("fill count beyond chain length");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with fill count");

  a_pend_has_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_PEND |-> out_valid)
    else $error("pending result without a held output beat");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    done && last_q |=> count == '0)
    else $error("last item did not empty the chain");
`endif

endmodule

### verif/prime_sieve_filter_chain_tb.sv
`timescale 1ns / 100ps
// testbench for prime_sieve_filter_chain: a short table of directed candidates, then random streams
// with bursty input and a stalling receiver; result beats are checked against a sieve kept here
// depends on psf_pkg and the prime_sieve_filter_chain rtl
module prime_sieve_filter_chain_tb;
  import psf_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int BEAT_TARGET  = 1750;
  localparam int DRAIN_CYCLES = 400;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    value_t cand;
    logic   last;
    logic   typed;
    logic   passes;
    logic   full;
  } sieve_row_t;

  typedef struct packed {
    value_t prime;
    logic   chain_full;
  } prime_beat_t;

  logic   clk        = 1'b0;
  logic   rst        = 1'b1;
  logic   in_valid   = 1'b0;
  logic   in_ready;
  value_t candidate  = '0;
  logic   last       = 1'b0;
  logic   out_valid;
  logic   out_ready  = 1'b0;
  value_t prime;
  logic   chain_full;

  value_t      kept_primes [MAX_PRIMES];
  int unsigned kept_count     = 0;
  prime_beat_t prime_q [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned gap_mode       = 0;
  int unsigned cycles         = 0;

  // cand, last, typed, passes, full
  sieve_row_t directed_rows [17] = '{
    '{16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b0},
    '{16'h0002, 1'b1, 1'b1, 1'b1, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 1'b1, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h000E, 1'b0, 1'b1, 1'b0, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 1'b0, 1'b0},
    '{16'h0001, 1'b0, 1'b1, 1'b1, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0},
    '{16'h0002, 1'b1, 1'b1, 1'b0, 1'b0},
    '{16'h8000, 1'b0, 1'b1, 1'b1, 1'b0},
    '{16'hFFFE, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'h0003, 1'b1, 1'b0, 1'b0, 1'b0},
    '{16'h0001, 1'b1, 1'b1, 1'b1, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0}
  };

  prime_sieve_filter_chain i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .candidate  (candidate),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .prime      (prime),
    .chain_full (chain_full)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  function automatic bit passes_filters(value_t cand);
    for (int i = 0; i < kept_count; i++) begin
      if (kept_primes[i] != '0 && (cand % kept_primes[i]) == '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatch_count++;
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_beat(sieve_row_t row);
    int unsigned gap;
    prime_beat_t beat;
    bit          passed;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case (gap_mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 4);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) :
                                                     $urandom_range(0, 4);
      endcase
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    candidate <= row.cand;
    last      <= row.last;
    do @(posedge clk); while (!in_ready);
    passed          = passes_filters(row.cand);
    beat.prime      = row.cand;
    beat.chain_full = (kept_count >= MAX_PRIMES);
    if (passed && !beat.chain_full) begin
      kept_primes[kept_count] = row.cand;
      kept_count++;
    end
    if (row.last) kept_count = 0;
    if (row.typed) begin
      passed          = row.passes;
      beat.chain_full = row.full;
    end
    if (passed) prime_q.push_back(beat);
    beats_sent++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    sieve_row_t  row;
    int unsigned run_len;
    int unsigned kind;
    int unsigned start;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    gap_mode = 1;
    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    while (beats_sent < BEAT_TARGET) begin
      kind     = $urandom_range(0, 9);
      gap_mode = $urandom_range(0, 2);
      run_len  = (kind < 4) ? $urandom_range(30, 80) : $urandom_range(1, 40);
      start    = $urandom_range(2, 40);
      if (kind == 4 && $urandom_range(0, 5) == 0) begin
        start   = 2;
        run_len = $urandom_range(310, 340);
      end
      for (int n = 0; n < run_len; n++) begin
        row.typed  = 1'b0;
        row.passes = 1'b0;
        row.full   = 1'b0;
        row.last   = (n == run_len - 1);
        case (kind)
          0, 1, 2, 3: begin
            // mostly candidates that get through, so the chain fills up
            row.cand = value_t'($urandom_range(0, 65535));
            for (int t = 0; t < 8 && !passes_filters(row.cand); t++)
              row.cand = value_t'($urandom_range(0, 65535));
          end
          4, 5: row.cand = value_t'(start + n);
          6, 7: row.cand = value_t'($urandom_range(0, 1) ? $urandom_range(0, 255) :
                                                           $urandom_range(0, 65535));
          default: begin
            row.cand = value_t'($urandom_range(0, 65535));
            row.last = ($urandom_range(0, 3) == 0);
          end
        endcase
        send_beat(row);
      end
    end
    in_valid <= 1'b0;
    while (prime_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned stall_mode;
    int unsigned stall_len;
    logic [15:0] stall_pattern;
    forever begin
      stall_mode    = $urandom_range(0, 3);
      stall_len     = $urandom_range(1, 150);
      stall_pattern = 16'($urandom_range(0, 65535));
      for (int n = 0; n < 256; n++) begin
        @(negedge clk);
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= stall_pattern[n % 16];
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= (n < 64) || (n >= 64 + stall_len);
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    prime_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (prime_q.size() == 0) begin
        report_mismatch("prime beat with nothing pending", prime, -1);
      end else begin
        want = prime_q.pop_front();
        if (prime !== want.prime) report_mismatch("prime", prime, want.prime);
        if (chain_full !== want.chain_full)
          report_mismatch("chain_full", chain_full, want.chain_full);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
